// ===== rtl/white_blob_steering_top_assert.svh =====
// assertion macros for the white blob steering rtl, used by wbs_back
`ifndef WHITE_BLOB_STEERING_TOP_ASSERT_SVH
`define WHITE_BLOB_STEERING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define WBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define WBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wbs_pkg.sv =====
// types and constants shared by the white blob steering modules
`default_nettype none

package wbs_pkg;

   localparam int SUM_W      = 37;
   localparam int COUNT_W    = 25;
   localparam int MEAN_W     = 12;
   localparam int SIZE_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   localparam logic [7:0] WHITE_LEVEL = 8'hFF;

   localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [COUNT_W-1:0] NEAR_COUNT_RESET   = 25'd100000;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_COUNT   = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_LEFT    = 3'd1,
      CMD_RIGHT   = 3'd2,
      CMD_FORWARD = 3'd3,
      CMD_NEAR    = 3'd4
   } command_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      command_type        command;
      logic [COUNT_W-1:0] pixel_count;
      logic [MEAN_W-1:0]  mean_column;
   } rsp_type;

   // per-frame totals handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0]   column_sum;
      logic [COUNT_W-1:0] white_total;
   } tally_type;

endpackage

`default_nettype wire

// ===== rtl/wbs_queue.sv =====
// two-entry queue of frame totals between the pixel front end and the divider
`default_nettype none

module wbs_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wbs_pkg::tally_type    push_data,
   output logic                  full,
   input  wire                   pop,
   output wbs_pkg::tally_type    pop_data,
   output logic                  empty
);
   import wbs_pkg::*;

   tally_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wbs_front.sv =====
// pixel front end: raster position, white test and per-frame accumulation
`default_nettype none

module wbs_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wbs_pkg::req_type      req_data,
   input  wire  [WW-1:0]         width_eff,
   input  wire  [HW-1:0]         height_eff,
   input  wire                   queue_full,
   output logic                  push,
   output wbs_pkg::tally_type    push_data
);
   import wbs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]      column_ff;
   logic [HW-1:0]      row_ff;
   logic [COUNT_W-1:0] white_total_ff;
   logic [SUM_W-1:0]   column_sum_ff;

   logic [CW-1:0]      column_in;
   logic [HW-1:0]      row_in;
   logic [COUNT_W-1:0] white_total_in;
   logic [SUM_W-1:0]   column_sum_in;

   logic               last_col;
   logic               last_px;
   logic               accept;
   logic               white;
   logic [COUNT_W-1:0] total_add;
   logic [SUM_W-1:0]   sum_add;

   // a width shrunk mid-row wraps the column at once
   assign last_col  = (WW'(column_ff) + WW'(1)) >= width_eff;
   assign last_px   = last_col && ((row_ff + HW'(1)) >= height_eff);
   assign req_ready = !(queue_full && last_px);
   assign accept    = req_valid && req_ready;

   assign white = (req_data.red == WHITE_LEVEL) && (req_data.green == WHITE_LEVEL)
                  && (req_data.blue == WHITE_LEVEL);

   assign total_add = white_total_ff + COUNT_W'(white);
   assign sum_add   = column_sum_ff + (white ? SUM_W'(column_ff) : '0);

   assign push                  = accept && last_px;
   assign push_data.column_sum  = sum_add;
   assign push_data.white_total = total_add;

   always_comb begin
      column_in      = column_ff;
      row_in         = row_ff;
      white_total_in = white_total_ff;
      column_sum_in  = column_sum_ff;
      if (accept) begin
         if (last_col) begin
            column_in = '0;
            row_in    = last_px ? '0 : row_ff + HW'(1);
         end else begin
            column_in = column_ff + CW'(1);
         end
         white_total_in = last_px ? '0 : total_add;
         column_sum_in  = last_px ? '0 : sum_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         row_ff         <= '0;
         white_total_ff <= '0;
         column_sum_ff  <= '0;
      end else begin
         column_ff      <= column_in;
         row_ff         <= row_in;
         white_total_ff <= white_total_in;
         column_sum_ff  <= column_sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wbs_back.sv =====
// back end: bit-serial mean division, steering decision and result register
`default_nettype none
`include "white_blob_steering_top_assert.svh"

module wbs_back #(
   parameter int MAX_WIDTH = 4096,
   localparam int WW = $clog2(MAX_WIDTH + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          pop_valid,
   output logic                         pop,
   input  wbs_pkg::tally_type           pop_data,
   input  wire  [WW-1:0]                width_eff,
   input  wire  [wbs_pkg::COUNT_W-1:0]  near_count,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output wbs_pkg::rsp_type             rsp_data
);
   import wbs_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DECIDE
   } state_type;

   state_type          state_ff;
   logic [SUM_W-1:0]   quot_ff;
   logic [COUNT_W:0]   rem_ff;
   logic [COUNT_W-1:0] divisor_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [COUNT_W:0]   shifted;
   logic               fits;
   logic [COUNT_W:0]   rem_in;
   logic [SUM_W-1:0]   quot_in;
   logic               out_free;
   logic [WW-1:0]      quarter;
   logic [WW+1:0]      three_w;
   logic [WW-1:0]      three_q;
   rsp_type            rsp_in;
   logic               in_decide;
   logic               div_more;
   logic               none_ok;

   // one quotient bit per cycle, dividend shifts out as quotient shifts in
   assign shifted = {rem_ff[COUNT_W-1:0], quot_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign rem_in  = fits ? (shifted - {1'b0, divisor_ff}) : shifted;
   assign quot_in = {quot_ff[SUM_W-2:0], fits};

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == ST_IDLE) && pop_valid;

   assign quarter = width_eff >> 2;
   assign three_w = {1'b0, width_eff, 1'b0} + (WW+2)'(width_eff);
   assign three_q = WW'(three_w >> 2);

   always_comb begin
      rsp_in.pixel_count = divisor_ff;
      rsp_in.mean_column = quot_ff[MEAN_W-1:0];
      if (divisor_ff == '0) begin
         rsp_in.command     = CMD_NONE;
         rsp_in.mean_column = '0;
      end else if (quot_ff < SUM_W'(quarter)) begin
         rsp_in.command = CMD_LEFT;
      end else if (quot_ff > SUM_W'(three_q)) begin
         rsp_in.command = CMD_RIGHT;
      end else if (divisor_ff < near_count) begin
         rsp_in.command = CMD_FORWARD;
      end else begin
         rsp_in.command = CMD_NEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in decide the valid bit is handled below
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DECIDE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  quot_ff    <= pop_data.column_sum;
                  divisor_ff <= pop_data.white_total;
                  rem_ff     <= '0;
                  step_ff    <= STEP_W'(SUM_W);
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               quot_ff <= quot_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_data_ff  <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_decide = (state_ff == ST_DECIDE);
   assign div_more  = (state_ff == ST_DIV) && (step_ff != STEP_W'(1));
   assign none_ok   = (rsp_data_ff.command == CMD_NONE) == (rsp_data_ff.pixel_count == '0);

   `WBS_ASSERT_NOW(a_result_from_decide, $rose(rsp_valid_ff), $past(in_decide), "result early")
   `WBS_ASSERT_NEXT(a_div_runs_full_length, div_more, state_ff == ST_DIV, "division cut short")
   `WBS_ASSERT_NOW(a_none_iff_no_white, rsp_valid_ff, none_ok, "no-blob command vs count")

endmodule

`default_nettype wire

// ===== rtl/white_blob_steering_top.sv =====
// top level of the white blob steering block: config registers and module wiring
//
// Pixels enter on the req_ channel (valid/ready) in raster order, one per transfer,
// as red/green/blue bytes. The block tracks column and row from frame_width and
// frame_height (0 reads as 1, values above MAX_WIDTH/MAX_HEIGHT read as the maximum).
// For each frame one command leaves on the rsp_ channel with the
// white pixel count and the truncated mean column of the white pixels.
// Throughput: one pixel per cycle while req_ready is high. Frame totals wait in a
// two-entry queue for the back end, which takes a new total only when idle and then
// runs a bit-serial divider and a decision step; frames that arrive faster than the
// back end clears them make the front end hold req_ready low on a frame's last pixel
// while the queue is full.
// A stalled rsp_ receiver holds the result register; pixels keep flowing until the
// queue fills. Reset (synchronous, active high) empties the queue, clears position
// and totals, and loads the registers with 640 x 480 and a near count of 100000.
// csr_ writes are registered, with no read-back; an unknown index is ignored.
`default_nettype none

module white_blob_steering_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wbs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output wbs_pkg::rsp_type                rsp_data,
   input  wire                             csr_wr_en,
   input  wire  [wbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [wbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wbs_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [SIZE_W-1:0]  frame_width_ff;
   logic [SIZE_W-1:0]  frame_height_ff;
   logic [COUNT_W-1:0] near_count_ff;

   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_eff;

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   tally_type push_data;
   tally_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         near_count_ff   <= NEAR_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_NEAR_COUNT:   near_count_ff   <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(frame_height_ff);
      end
   end

   wbs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   wbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   wbs_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (!queue_empty),
      .pop        (pop),
      .pop_data   (pop_data),
      .width_eff  (width_eff),
      .near_count (near_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
